### hdl/htlcd_pkg.sv
// Shared types, constants and small helpers for the timer / LCD status /
// interrupt unit. No dependencies; imported by htlcd_step and the top level.
package htlcd_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TIMER_CONTROL    = 3'd0,
    REG_TIMER_RELOAD     = 3'd1,
    REG_LINE_COMPARE     = 3'd2,
    REG_INTERRUPT_ENABLE = 3'd3,
    REG_STAT_SELECT      = 3'd4
  } reg_idx_t;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_POLL   = 1'b1;

  // LCD timing, in machine cycles and lines
  localparam int LINE_CYCLES  = 114;
  localparam int OAM_END      = 20;
  localparam int XFER_END     = 63;
  localparam int XFER_EVENT   = 64;
  localparam logic [7:0] LAST_LINE    = 8'd153;
  localparam logic [7:0] VBLANK_LINE  = 8'd144;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // interrupt request flag positions
  localparam int IRQ_VBLANK = 0;
  localparam int IRQ_STAT   = 1;
  localparam int IRQ_TIMER  = 2;
  localparam int IRQ_SERIAL = 3;
  localparam int IRQ_JOYPAD = 4;

  // STAT source select positions
  localparam int SEL_MODE0 = 0;
  localparam int SEL_MODE1 = 1;
  localparam int SEL_MODE2 = 2;
  localparam int SEL_LYC   = 3;

  localparam int TAC_ENABLE = 2;

  localparam logic [6:0] VEC_NONE   = 7'h00;
  localparam logic [6:0] VEC_VBLANK = 7'h40;
  localparam logic [6:0] VEC_STAT   = 7'h48;
  localparam logic [6:0] VEC_TIMER  = 7'h50;
  localparam logic [6:0] VEC_JOYPAD = 7'h60;

  typedef struct packed {
    logic [2:0] timer_control;
    logic [7:0] timer_reload;
    logic [7:0] line_compare;
    logic [4:0] interrupt_enable;
    logic [3:0] stat_select;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] timer_count;
    logic [7:0] divider_count;
    logic [7:0] line_count;
    logic [1:0] mode;
    logic       coincidence;
    logic [4:0] requests;
  } cnt_state_t;

  typedef struct packed {
    logic       render_line;
    logic       interrupt_taken;
    logic       master_enable_after;
    logic [6:0] vector;
    logic [4:0] pending_flags;
    logic [7:0] timer_value;
    logic [7:0] divider_value;
    logic       coincidence;
    logic [1:0] lcd_mode;
    logic [7:0] line;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

  // tick period selected by timer_control[1:0]
  function automatic logic [8:0] period_of(input logic [1:0] sel);
    logic [8:0] p;
    case (sel)
      2'd0: p = 9'd256;
      2'd1: p = 9'd4;
      2'd2: p = 9'd16;
      2'd3: p = 9'd64;
      default: p = 9'd256;
    endcase
    return p;
  endfunction

endpackage

### hdl/htlcd_step.sv
// Next-state and result logic for one update or poll item.
// Depends on htlcd_pkg; instantiated by handheld_timer_lcd_interrupt_unit.
module htlcd_step import htlcd_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  cfg_regs_t            cfg,
  input  cnt_state_t           st,
  input  logic [TIME_BITS-1:0] timer_mark,
  input  logic [TIME_BITS-1:0] divider_mark,
  input  logic [TIME_BITS-1:0] line_mark,
  input  logic                 req_type,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 master_enable,
  output cnt_state_t           st_next,
  output logic [TIME_BITS-1:0] timer_mark_next,
  output logic [TIME_BITS-1:0] divider_mark_next,
  output logic [TIME_BITS-1:0] line_mark_next,
  output result_t              res,
  output logic [TIME_BITS-1:0] next_event_time
);

  logic [TIME_BITS-1:0] period;
  logic [TIME_BITS-1:0] timer_due;
  logic [TIME_BITS-1:0] divider_due;
  logic [TIME_BITS-1:0] line_due;
  logic [TIME_BITS-1:0] line_age;
  logic [TIME_BITS-1:0] now_plus_period;
  logic [TIME_BITS-1:0] now_plus_line;
  logic [TIME_BITS-1:0] now_plus_oam;
  logic [TIME_BITS-1:0] now_plus_xfer;
  logic [TIME_BITS-1:0] mark_plus_oam;
  logic [TIME_BITS-1:0] mark_plus_xfer;
  logic                 timer_hit;
  logic                 divider_hit;
  logic                 line_hit;
  logic [7:0]           line_inc;

  assign period          = TIME_BITS'(period_of(cfg.timer_control[1:0]));
  assign timer_due       = timer_mark + period;
  assign divider_due     = divider_mark + period;
  assign line_due        = line_mark + TIME_BITS'(LINE_CYCLES);
  assign line_age        = now - line_mark;
  assign now_plus_period = now + period;
  assign now_plus_line   = now + TIME_BITS'(LINE_CYCLES);
  assign now_plus_oam    = now + TIME_BITS'(OAM_END);
  assign now_plus_xfer   = now + TIME_BITS'(XFER_EVENT);
  assign mark_plus_oam   = line_mark + TIME_BITS'(OAM_END);
  assign mark_plus_xfer  = line_mark + TIME_BITS'(XFER_EVENT);
  assign timer_hit       = now > timer_due;
  assign divider_hit     = now > divider_due;
  assign line_hit        = now > line_due;
  assign line_inc        = (st.line_count == LAST_LINE) ? 8'd0 : st.line_count + 8'd1;

  logic [TIME_BITS-1:0] age;
  logic [4:0]           pend;

  always_comb begin
    st_next           = st;
    timer_mark_next   = timer_mark;
    divider_mark_next = divider_mark;
    line_mark_next    = line_mark;
    res               = '0;
    res.vector        = VEC_NONE;
    res.master_enable_after = master_enable;
    age               = line_hit ? '0 : line_age;
    pend              = cfg.interrupt_enable & st.requests;

    if (req_type == REQ_UPDATE) begin
      if (timer_hit) begin
        timer_mark_next = now;
        if (cfg.timer_control[TAC_ENABLE]) begin
          if (st.timer_count == 8'hff) begin
            st_next.timer_count = cfg.timer_reload;
            st_next.requests[IRQ_TIMER] = 1'b1;
          end else begin
            st_next.timer_count = st.timer_count + 8'd1;
          end
        end
      end
      if (divider_hit) begin
        divider_mark_next     = now;
        st_next.divider_count = st.divider_count + 8'd1;
      end
      st_next.coincidence = 1'b0;
      if (line_hit) begin
        line_mark_next     = now;
        st_next.line_count = line_inc;
        res.render_line    = line_inc < VBLANK_LINE;
        if (line_inc == cfg.line_compare) begin
          st_next.coincidence = 1'b1;
          if (cfg.stat_select[SEL_LYC]) st_next.requests[IRQ_STAT] = 1'b1;
        end
        if (line_inc == VBLANK_LINE) begin
          st_next.requests[IRQ_VBLANK] = 1'b1;
          if (cfg.stat_select[SEL_MODE1] && st.mode != MODE_VBLANK)
            st_next.requests[IRQ_STAT] = 1'b1;
          st_next.mode = MODE_VBLANK;
        end
      end
      // mode within a visible line follows the time since the line began
      if (st_next.line_count < VBLANK_LINE) begin
        if (age < TIME_BITS'(OAM_END)) begin
          if (cfg.stat_select[SEL_MODE2] && st.mode != MODE_OAM)
            st_next.requests[IRQ_STAT] = 1'b1;
          st_next.mode = MODE_OAM;
        end else if (age < TIME_BITS'(XFER_END)) begin
          st_next.mode = MODE_XFER;
        end else begin
          if (cfg.stat_select[SEL_MODE0] && st.mode != MODE_HBLANK)
            st_next.requests[IRQ_STAT] = 1'b1;
          st_next.mode = MODE_HBLANK;
        end
      end
    end else if (master_enable) begin
      if (pend[IRQ_VBLANK]) begin
        st_next.requests[IRQ_VBLANK] = 1'b0;
        res.vector = VEC_VBLANK;
      end else if (pend[IRQ_STAT]) begin
        st_next.requests[IRQ_STAT] = 1'b0;
        res.vector = VEC_STAT;
      end else if (pend[IRQ_TIMER]) begin
        st_next.requests[IRQ_TIMER] = 1'b0;
        res.vector = VEC_TIMER;
      end else begin
        // serial only drops master enable; joypad still dispatches
        if (pend[IRQ_SERIAL]) res.master_enable_after = 1'b0;
        if (pend[IRQ_JOYPAD]) begin
          st_next.requests[IRQ_JOYPAD] = 1'b0;
          res.vector = VEC_JOYPAD;
        end
      end
      if (res.vector != VEC_NONE) begin
        res.master_enable_after = 1'b0;
        res.interrupt_taken     = 1'b1;
      end
    end

    res.line          = st_next.line_count;
    res.lcd_mode      = st_next.mode;
    res.coincidence   = st_next.coincidence;
    res.divider_value = st_next.divider_count;
    res.timer_value   = st_next.timer_count;
    res.pending_flags = st_next.requests;
  end

  // earliest of line end, next tick and the next mode edge in this line
  logic [TIME_BITS-1:0] line_end;
  logic [TIME_BITS-1:0] mode_edge;
  logic [TIME_BITS-1:0] first_two;

  always_comb begin
    line_end  = (line_hit && req_type == REQ_UPDATE) ? now_plus_line : line_due;
    first_two = (line_end > now_plus_period) ? now_plus_period : line_end;
    mode_edge = first_two;
    if (st_next.mode == MODE_OAM) begin
      mode_edge = (line_hit && req_type == REQ_UPDATE) ? now_plus_oam : mark_plus_oam;
    end else if (st_next.mode == MODE_XFER) begin
      mode_edge = (line_hit && req_type == REQ_UPDATE) ? now_plus_xfer : mark_plus_xfer;
    end
    next_event_time = (first_two > mode_edge) ? mode_edge : first_two;
  end

endmodule

### hdl/handheld_timer_lcd_interrupt_unit.sv
// Top level of the timer / LCD status / interrupt unit: input register,
// timing state, result register. Depends on htlcd_pkg and htlcd_step.
//
// Usage:
//  s_* channel carries one item per beat: tuser is the kind (0 update,
//  1 poll), tdata holds the cycle count and the processor's master enable.
//  m_* channel returns exactly one result beat per input beat, in order.
//  cfg_* channel writes the five control registers (index 0..4, others are
//  dropped); write only while no item is in flight. cfg_ready is always high.
// Path: a beat taken is held in the input register, and its result is
//  registered in the result register and presented on m_* from there.
// Throughput: one item per cycle unless m_* stalls. Every item goes through
//  a single pass of htlcd_step, and the timing state it writes is ready for
//  the next item in the following cycle.
// Reset (rst, synchronous): control registers, counters, time marks and
//  flags go to zero, both pipeline registers empty.
// Stall: while m_tready is low the result holds; the input register still
//  takes one more beat, then s_tready drops until the result drains.
module handheld_timer_lcd_interrupt_unit import htlcd_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // now, master_enable
  input  logic [((TIME_BITS + 1 + 7) / 8) * 8 - 1:0]  s_tdata,
  // req_type
  input  logic                                        s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // line, lcd_mode, coincidence, divider_value, timer_value, pending_flags,
  // vector, master_enable_after, interrupt_taken, render_line, next_event_time
  output logic [((TIME_BITS + 42 + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]                   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                    cfg_data
);

  localparam int OutWidth = ((TIME_BITS + RESULT_BITS + 7) / 8) * 8;

  cfg_regs_t            cfg;
  cnt_state_t           st;
  cnt_state_t           st_next;
  logic [TIME_BITS-1:0] timer_mark, timer_mark_next;
  logic [TIME_BITS-1:0] divider_mark, divider_mark_next;
  logic [TIME_BITS-1:0] line_mark, line_mark_next;

  logic                 in_valid;
  logic                 in_req;
  logic [TIME_BITS-1:0] in_now;
  logic                 in_me;
  logic                 advance;

  result_t              res;
  logic [TIME_BITS-1:0] event_time;
  logic [OutWidth-1:0]  out_data;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_TIMER_CONTROL:    cfg.timer_control    <= cfg_data[2:0];
        REG_TIMER_RELOAD:     cfg.timer_reload     <= cfg_data;
        REG_LINE_COMPARE:     cfg.line_compare     <= cfg_data;
        REG_INTERRUPT_ENABLE: cfg.interrupt_enable <= cfg_data[4:0];
        REG_STAT_SELECT:      cfg.stat_select      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req <= s_tuser;
      in_now <= s_tdata[TIME_BITS-1:0];
      in_me  <= s_tdata[TIME_BITS];
    end
  end

  htlcd_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .cfg               (cfg),
    .st                (st),
    .timer_mark        (timer_mark),
    .divider_mark      (divider_mark),
    .line_mark         (line_mark),
    .req_type          (in_req),
    .now               (in_now),
    .master_enable     (in_me),
    .st_next           (st_next),
    .timer_mark_next   (timer_mark_next),
    .divider_mark_next (divider_mark_next),
    .line_mark_next    (line_mark_next),
    .res               (res),
    .next_event_time   (event_time)
  );

  // timing state advances with each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      timer_mark   <= '0;
      divider_mark <= '0;
      line_mark    <= '0;
    end else if (advance) begin
      st           <= st_next;
      timer_mark   <= timer_mark_next;
      divider_mark <= divider_mark_next;
      line_mark    <= line_mark_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= OutWidth'({event_time, res});
    end
  end

  // line counter stays within the frame
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] <= LAST_LINE))
    else $error("line counter out of range");

  // a dispatch always drops master enable
  a_taken_drops_ime: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[40] |-> !m_tdata[39])
    else $error("dispatch left master enable set");

  // a served vblank request flag is cleared in the stored timing state
  a_served_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && res.interrupt_taken && res.vector == VEC_VBLANK
      |=> !st.requests[IRQ_VBLANK])
    else $error("vblank flag still pending after dispatch");

  // a held input item is neither lost nor replaced
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_now) && $stable(in_req))
    else $error("input register overwritten while stalled");

endmodule
